>>> rtl/sha256_message_padder_core_defines.svh
`ifndef SHA256_MESSAGE_PADDER_CORE_DEFINES_SVH
`define SHA256_MESSAGE_PADDER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on i_clk and disabled during reset.
`define SHA_PAD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk and disabled during reset.
`define SHA_PAD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/sha_pad_pkg.sv
package sha_pad_pkg;

    localparam logic REQ_DATA = 1'b0;
    localparam logic REQ_END  = 1'b1;

    localparam logic [7:0] PAD_BYTE     = 8'h80;
    localparam logic [3:0] LAST_INDEX   = 4'hF;
    localparam logic [3:0] LEN_HI_INDEX = 4'hE;
    localparam logic [1:0] WORD_LAST_BYTE = 2'd3;
    localparam logic [63:0] BITS_PER_BYTE = 64'd8;

endpackage

>>> rtl/sha256_message_padder_core.sv
// SHA-256 message padder.
// Input channel (i_in_valid / o_in_ready): one item per message byte with
// i_req_type low, and one item with i_req_type high to close the message.
// Output channel (o_out_valid / i_out_ready): 32-bit big-endian words with
// their index in the 512-bit block, a block end flag and a message end flag.
// A data item is taken every cycle unless a padding run or an output stall
// holds it off; every fourth byte of a block produces one word, shown in
// the cycle after the item is accepted. An end item starts the padding run:
// 16 - bytes_in_block/4 words, or 16 more when 56 or more bytes are already
// in the block (at most 18 words). A word counter loads one word per cycle
// unless the output stalls, and input is held off until the last is loaded.
// The output register is the only buffer: when the receiver stalls, the
// current word holds and the next item or padding word waits.
// Reset clears the bit count, the block byte count, the partial word, the
// padding run and the output valid flag.
module sha256_message_padder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_req_type,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_padded_word,
    output logic [3:0]  o_word_index,
    output logic        o_block_end,
    output logic        o_message_end
);
    import sha_pad_pkg::*;

    logic [63:0] r_bit_count, n_bit_count;
    logic [5:0]  r_bytes, n_bytes;
    logic [23:0] r_partial, n_partial;
    logic        r_run, n_run;
    logic        r_ext, n_ext;
    logic [4:0]  r_pos, n_pos;
    logic        r_out_valid, n_out_valid;
    logic [31:0] r_word, n_word;
    logic [3:0]  r_idx, n_idx;
    logic        r_bend, n_bend;
    logic        r_mend, n_mend;

    logic        load_ok;
    logic        accept;
    logic [31:0] first_word;
    logic [31:0] run_word;
    logic        run_last;

    assign load_ok    = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_run && load_ok;
    assign accept     = i_in_valid && o_in_ready;
    assign run_last   = (r_pos == {r_ext, LAST_INDEX});

    always_comb begin
        case (r_bytes[1:0])
            2'd0:    first_word = {PAD_BYTE, 24'h0};
            2'd1:    first_word = {r_partial[7:0], PAD_BYTE, 16'h0};
            2'd2:    first_word = {r_partial[15:0], PAD_BYTE, 8'h0};
            default: first_word = {r_partial[23:0], PAD_BYTE};
        endcase
    end

    always_comb begin
        if (r_pos == {1'b0, r_bytes[5:2]}) begin
            run_word = first_word;
        end else if (r_pos == {r_ext, LEN_HI_INDEX}) begin
            run_word = r_bit_count[63:32];
        end else if (run_last) begin
            run_word = r_bit_count[31:0];
        end else begin
            run_word = 32'h0;
        end
    end

    always_comb begin
        n_bit_count = r_bit_count;
        n_bytes     = r_bytes;
        n_partial   = r_partial;
        n_run       = r_run;
        n_ext       = r_ext;
        n_pos       = r_pos;
        n_out_valid = r_out_valid && !i_out_ready;
        n_word      = r_word;
        n_idx       = r_idx;
        n_bend      = r_bend;
        n_mend      = r_mend;

        if (r_run) begin
            if (load_ok) begin
                n_out_valid = 1'b1;
                n_word      = run_word;
                n_idx       = r_pos[3:0];
                n_bend      = (r_pos[3:0] == LAST_INDEX);
                n_mend      = run_last;
                if (run_last) begin
                    n_run       = 1'b0;
                    n_bit_count = 64'h0;
                    n_bytes     = 6'h0;
                    n_partial   = 24'h0;
                end else begin
                    n_pos = r_pos + 5'd1;
                end
            end
        end else if (accept) begin
            if (i_req_type == REQ_END) begin
                n_run = 1'b1;
                n_ext = (r_bytes >= 6'd56);
                n_pos = {1'b0, r_bytes[5:2]};
            end else begin
                n_bit_count = r_bit_count + BITS_PER_BYTE;
                n_bytes     = r_bytes + 6'd1;
                if (r_bytes[1:0] == WORD_LAST_BYTE) begin
                    n_partial   = 24'h0;
                    n_out_valid = 1'b1;
                    n_word      = {r_partial, i_data_byte};
                    n_idx       = r_bytes[5:2];
                    n_bend      = (r_bytes[5:2] == LAST_INDEX);
                    n_mend      = 1'b0;
                end else begin
                    n_partial = {r_partial[15:0], i_data_byte};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_count <= 64'h0;
            r_bytes     <= 6'h0;
            r_partial   <= 24'h0;
            r_run       <= 1'b0;
            r_ext       <= 1'b0;
            r_pos       <= 5'h0;
            r_out_valid <= 1'b0;
        end else begin
            r_bit_count <= n_bit_count;
            r_bytes     <= n_bytes;
            r_partial   <= n_partial;
            r_run       <= n_run;
            r_ext       <= n_ext;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_idx  <= n_idx;
        r_bend <= n_bend;
        r_mend <= n_mend;
    end

    assign o_out_valid   = r_out_valid;
    assign o_padded_word = r_word;
    assign o_word_index  = r_idx;
    assign o_block_end   = r_bend;
    assign o_message_end = r_mend;

endmodule

>>> rtl/sha_pad_checker.sv
`include "sha256_message_padder_core_defines.svh"

module sha_pad_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        i_req_type,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_padded_word,
    input logic [3:0]  o_word_index,
    input logic        o_block_end,
    input logic        o_message_end
);
    import sha_pad_pkg::*;

    `SHA_PAD_ASSERT_NEXT(a_stall_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_padded_word), "stalled item changed")
    `SHA_PAD_ASSERT_NOW(a_block_end_idx, o_out_valid, o_block_end == (o_word_index == LAST_INDEX), "block end flag does not match index")
    `SHA_PAD_ASSERT_NOW(a_msg_end_block, o_out_valid && o_message_end, o_block_end, "message ended inside a block")
    `SHA_PAD_ASSERT_NEXT(a_end_holds_input, i_in_valid && o_in_ready && (i_req_type == REQ_END), !o_in_ready, "input taken during padding run")

endmodule

bind sha256_message_padder_core sha_pad_checker u_sha_pad_checker (.*);
